### rtl/a64rel_pkg.sv
`default_nettype none

package a64rel_pkg;

  typedef enum logic [2:0] {
    CLS_OTHER  = 3'd0,
    CLS_ADR    = 3'd1,
    CLS_LDRLIT = 3'd2,
    CLS_BBL    = 3'd3,
    CLS_BCOND  = 3'd4,
    CLS_CBZ    = 3'd5,
    CLS_TBZ    = 3'd6
  } cls_t;

  localparam logic [31:0] ADR_MASK    = 32'h9F00_0000;
  localparam logic [31:0] ADR_VAL     = 32'h1000_0000;
  localparam logic [31:0] ADRP_VAL    = 32'h9000_0000;
  localparam logic [31:0] LDRLIT_MASK = 32'h3B00_0000;
  localparam logic [31:0] LDRLIT_VAL  = 32'h1800_0000;
  localparam logic [31:0] BBL_MASK    = 32'h7C00_0000;
  localparam logic [31:0] BBL_VAL     = 32'h1400_0000;
  localparam logic [31:0] BCOND_MASK  = 32'hFF00_0010;
  localparam logic [31:0] BCOND_VAL   = 32'h5400_0000;
  localparam logic [31:0] CB_MASK     = 32'h7E00_0000;
  localparam logic [31:0] CBZ_VAL     = 32'h3400_0000;
  localparam logic [31:0] TBZ_VAL     = 32'h3600_0000;

  typedef struct packed {
    logic [31:0] relocated_word;
    logic        overflow;
    cls_t        instruction_class;
  } rel_result_t;

  function automatic cls_t classify(input logic [31:0] w);
    cls_t c;
    if ((w & ADR_MASK) == ADR_VAL || (w & ADR_MASK) == ADRP_VAL) c = CLS_ADR;
    else if ((w & LDRLIT_MASK) == LDRLIT_VAL) c = CLS_LDRLIT;
    else if ((w & BBL_MASK) == BBL_VAL) c = CLS_BBL;
    else if ((w & BCOND_MASK) == BCOND_VAL) c = CLS_BCOND;
    else if ((w & CB_MASK) == CBZ_VAL) c = CLS_CBZ;
    else if ((w & CB_MASK) == TBZ_VAL) c = CLS_TBZ;
    else c = CLS_OTHER;
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/a64rel_if.sv
`default_nettype none

interface a64rel_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction_word;
  logic [63:0] source_address;
  logic [63:0] dest_address;

  modport source (output valid, instruction_word, source_address, dest_address,
                  input ready);
  modport sink (input valid, instruction_word, source_address, dest_address,
                output ready);
endinterface

interface a64rel_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] relocated_word;
  logic        overflow;
  logic [2:0]  instruction_class;

  modport source (output valid, relocated_word, overflow, instruction_class,
                  input ready);
  modport sink (input valid, relocated_word, overflow, instruction_class,
                output ready);
endinterface

`default_nettype wire

### rtl/a64rel_encode.sv
`default_nettype none

module a64rel_encode
  import a64rel_pkg::*;
(
  input  logic [31:0]  word,
  input  logic [63:0]  src,
  input  logic [63:0]  dst,
  output rel_result_t  result
);

  cls_t        cls;
  logic [20:0] adr_imm;
  logic [63:0] off;
  logic [63:0] d;
  logic [51:0] page;
  logic        fit20;
  logic        fit27;
  logic        fit15;
  logic        fit_page;
  logic        is_adrp;
  logic [20:0] nimm;
  logic        fits;
  logic [31:0] res;

  assign cls     = classify(word);
  assign adr_imm = {word[23:5], word[30:29]};
  assign is_adrp = word[31];

  always_comb begin
    case (cls)
      CLS_ADR: off = {{43{adr_imm[20]}}, adr_imm};
      CLS_BBL: off = {{36{word[25]}}, word[25:0], 2'b00};
      CLS_TBZ: off = {{48{word[18]}}, word[18:5], 2'b00};
      default: off = {{43{word[23]}}, word[23:5], 2'b00};
    endcase
  end

  assign d    = src + off - dst;
  assign page = src[63:12] + {{31{adr_imm[20]}}, adr_imm} - dst[63:12];

  assign fit20    = (&d[63:20]) || !(|d[63:20]);
  assign fit27    = (&d[63:27]) || !(|d[63:27]);
  assign fit15    = (&d[63:15]) || !(|d[63:15]);
  assign fit_page = (&page[51:20]) || !(|page[51:20]);

  assign nimm = is_adrp ? page[20:0] : d[20:0];

  always_comb begin
    res  = word;
    fits = 1'b1;
    case (cls)
      CLS_ADR: begin
        fits         = is_adrp ? fit_page : fit20;
        res[30:29]   = nimm[1:0];
        res[23:5]    = nimm[20:2];
      end
      CLS_BBL: begin
        fits      = fit27;
        res[25:0] = d[27:2];
      end
      CLS_TBZ: begin
        fits      = fit15;
        res[18:5] = d[15:2];
      end
      CLS_LDRLIT, CLS_BCOND, CLS_CBZ: begin
        fits      = fit20;
        res[23:5] = d[20:2];
      end
      default: begin
        fits = 1'b1;
      end
    endcase
  end

  assign result.relocated_word    = fits ? res : 32'd0;
  assign result.overflow          = !fits;
  assign result.instruction_class = cls;

endmodule

`default_nettype wire

### rtl/aarch64_pc_relative_relocator.sv
`default_nettype none

// Channel | Direction | Payload
// req     | in        | instruction_word, source_address, dest_address
// rsp     | out       | relocated_word, overflow, instruction_class
//
// Each item passes an input register and a result register, and the block
// takes one item per cycle when rsp keeps ready high.
// The address adders and range checks sit combinationally between them.
// Reset (rst, synchronous) empties both registers; there is no other state.
// When rsp stalls, both registers hold and req.ready falls once they are full.

module aarch64_pc_relative_relocator
  import a64rel_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  a64rel_req_if.sink          req,
  a64rel_rsp_if.source        rsp
);

  logic        s1_valid;
  logic [31:0] s1_word;
  logic [63:0] s1_src;
  logic [63:0] s1_dst;
  logic        out_valid;
  rel_result_t out_result;
  rel_result_t enc_result;
  logic        s2_load;
  logic        s1_load;

  assign s2_load   = !out_valid || rsp.ready;
  assign s1_load   = !s1_valid || s2_load;
  assign req.ready = s1_load;

  a64rel_encode u_encode (
    .word   (s1_word),
    .src    (s1_src),
    .dst    (s1_dst),
    .result (enc_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= req.valid;
      end
      if (s2_load) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && req.valid) begin
      s1_word <= req.instruction_word;
      s1_src  <= req.source_address;
      s1_dst  <= req.dest_address;
    end
    if (s2_load && s1_valid) begin
      out_result <= enc_result;
    end
  end

  assign rsp.valid             = out_valid;
  assign rsp.relocated_word    = out_result.relocated_word;
  assign rsp.overflow          = out_result.overflow;
  assign rsp.instruction_class = out_result.instruction_class;

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`default_nettype none

module testbench;
  import a64rel_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  class reloc_checker;
    rel_result_t pending_relocs[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function bit fits_signed(logic [63:0] v, int unsigned k);
      logic [63:0] upper;
      upper = $signed(v) >>> k;
      return (upper == '0) || (upper == '1);
    endfunction

    function rel_result_t relocate(logic [31:0] w, logic [63:0] src, logic [63:0] dst);
      rel_result_t r;
      cls_t kind;
      logic [63:0] off;
      logic [63:0] tgt;
      logic [63:0] d;
      logic [31:0] word;
      logic bad;
      word = w;
      bad = 1'b0;
      if (w[28:24] == 5'b10000) kind = CLS_ADR;
      else if ({w[29:27], w[25:24]} == 5'b01100) kind = CLS_LDRLIT;
      else if (w[30:26] == 5'b00101) kind = CLS_BBL;
      else if (w[31:24] == 8'h54 && !w[4]) kind = CLS_BCOND;
      else if (w[30:25] == 6'b011010) kind = CLS_CBZ;
      else if (w[30:25] == 6'b011011) kind = CLS_TBZ;
      else kind = CLS_OTHER;
      case (kind)
        CLS_ADR: begin
          off = {{43{w[23]}}, w[23:5], w[30:29]};
          if (w[31]) begin
            // ADRP works on 4 KiB pages, so the immediate counts pages.
            tgt = {src[63:12], 12'h000} + (off << 12);
            d = tgt - {dst[63:12], 12'h000};
            d = $signed(d) >>> 12;
          end else begin
            d = src + off - dst;
          end
          bad = !fits_signed(d, 20);
          word[23:5] = d[20:2];
          word[30:29] = d[1:0];
        end
        CLS_BBL: begin
          off = {{36{w[25]}}, w[25:0], 2'b00};
          d = src + off - dst;
          bad = !fits_signed(d, 27);
          word[25:0] = d[27:2];
        end
        CLS_TBZ: begin
          off = {{48{w[18]}}, w[18:5], 2'b00};
          d = src + off - dst;
          bad = !fits_signed(d, 15);
          word[18:5] = d[15:2];
        end
        CLS_LDRLIT, CLS_BCOND, CLS_CBZ: begin
          off = {{43{w[23]}}, w[23:5], 2'b00};
          d = src + off - dst;
          bad = !fits_signed(d, 20);
          word[23:5] = d[20:2];
        end
        default: begin
        end
      endcase
      r.relocated_word = bad ? 32'h0 : word;
      r.overflow = bad;
      r.instruction_class = kind;
      return r;
    endfunction

    function void note_request(logic [31:0] w, logic [63:0] src, logic [63:0] dst);
      pending_relocs = {pending_relocs, relocate(w, src, dst)};
    endfunction

    function void check_response(logic [31:0] word, logic ovf, logic [2:0] kind);
      rel_result_t want;
      if (pending_relocs.size() == 0) begin
        $error("result with no item outstanding: word %h overflow %0d class %0d",
               word, ovf, kind);
        errors++;
        return;
      end
      want = pending_relocs.pop_front();
      if (word !== want.relocated_word) begin
        $error("relocated_word: expected %h, actual %h", want.relocated_word, word);
        errors++;
      end
      if (ovf !== want.overflow) begin
        $error("overflow: expected %0d, actual %0d", want.overflow, ovf);
        errors++;
      end
      if (kind !== want.instruction_class) begin
        $error("instruction_class: expected %0d, actual %0d",
               want.instruction_class, kind);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_relocs.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  int send_idle_pct;
  int stall_pct;
  reloc_checker relocs = new;

  a64rel_req_if req_ch ();
  a64rel_rsp_if rsp_ch ();

  aarch64_pc_relative_relocator dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        relocs.note_request(req_ch.instruction_word, req_ch.source_address,
                            req_ch.dest_address);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        relocs.check_response(rsp_ch.relocated_word, rsp_ch.overflow,
                              rsp_ch.instruction_class);
      end
    end
  end

  task automatic offer_instruction(input logic [31:0] w, input logic [63:0] src,
                                   input logic [63:0] dst);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.instruction_word <= w;
    req_ch.source_address <= src;
    req_ch.dest_address <= dst;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (relocs.outstanding() > 0) @(posedge clk);
  endtask

  task automatic run_directed();
    logic [63:0] base;
    base = 64'h0000_0040_1234_5000;
    offer_instruction(32'h0000_0000, base, base + 64'h100);
    offer_instruction(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
    offer_instruction(32'h1000_0000, 64'h1000, 64'h2000);
    offer_instruction(32'h707F_FFE0, base, base);
    offer_instruction(32'h707F_FFE0, base, base - 64'h1);
    offer_instruction(32'h1080_0000, base, base + 64'h7);
    offer_instruction(32'h9000_0001, 64'h1234_5678, 64'hFFFF_0123);
    offer_instruction(32'h9000_0001, 64'h0, 64'h0001_0000_0000_0000);
    offer_instruction(32'hB000_0002, 64'hFFFF_FFFF_FFFF_F000, 64'h0);
    offer_instruction(32'h5800_0020, 64'h1000, 64'h1003);
    offer_instruction(32'h1800_0000, base + 64'hF_FFFC, base);
    offer_instruction(32'h1800_0000, base + 64'h10_0000, base);
    offer_instruction(32'h1400_0000, base - 64'h800_0000, base);
    offer_instruction(32'h97FF_FFFF, base - 64'h800_0000, base);
    offer_instruction(32'h5400_000F, base, base + 64'h40);
    offer_instruction(32'h5400_0010, base, base + 64'h40);
    offer_instruction(32'h3400_0000, base, base - 64'hF_FFFC);
    offer_instruction(32'hB5FF_FFFF, base + 64'h2, base);
    offer_instruction(32'h3600_0000, base + 64'h8000, base);
    offer_instruction(32'hB7FF_FFFF, base - 64'h7FFC, base);
    offer_instruction(32'h1400_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
    offer_instruction(32'h1400_0000, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    drain_results();
  endtask

  task automatic run_random(input int count);
    logic [31:0] w;
    logic [31:0] mask;
    logic [31:0] val;
    logic [63:0] src;
    logic [63:0] dst;
    logic [63:0] delta;
    for (int i = 0; i < count; i++) begin
      w = $urandom;
      mask = 32'h0;
      val = 32'h0;
      case ($urandom_range(0, 9))
        0: begin mask = ADR_MASK; val = ADR_VAL; end
        1: begin mask = ADR_MASK; val = ADRP_VAL; end
        2: begin mask = LDRLIT_MASK; val = LDRLIT_VAL; end
        3: begin mask = BBL_MASK; val = BBL_VAL; end
        4: begin mask = BCOND_MASK; val = BCOND_VAL; end
        5: begin mask = CB_MASK; val = CBZ_VAL; end
        6: begin mask = CB_MASK; val = TBZ_VAL; end
        default: begin end
      endcase
      w = (w & ~mask) | val;
      src = {$urandom, $urandom};
      if ($urandom_range(0, 4) == 0) begin
        dst = {$urandom, $urandom};
      end else begin
        delta = {$urandom, $urandom};
        delta = $signed(delta) >>> $urandom_range(30, 63);
        dst = src + delta;
      end
      offer_instruction(w, src, dst);
    end
    drain_results();
  endtask

  initial begin
    rst = 1'b1;
    send_idle_pct = 14;
    stall_pct = 14;
    req_ch.valid = 1'b0;
    req_ch.instruction_word = 32'h0;
    req_ch.source_address = 64'h0;
    req_ch.dest_address = 64'h0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    send_idle_pct = 0;
    stall_pct = 0;
    run_random(450);
    send_idle_pct = 84;
    stall_pct = 0;
    run_random(450);
    send_idle_pct = 0;
    stall_pct = 84;
    run_random(450);
    send_idle_pct = 14;
    stall_pct = 14;
    run_random(450);
    repeat (10) @(posedge clk);
    if (relocs.errors == 0 && relocs.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
